[src/sha1md_pkg.sv]
`timescale 1ns / 1ps

package sha1md_pkg;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_GROUP0 = 32'h5A827999;
  localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

  // Initial chaining words of every message.
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Padding marker that follows the last message byte.
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Fill positions that matter to the controller.
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST      = 6'd63;

  // Round count: rounds 0..79, then the chaining update at round 80.
  localparam logic [6:0] ROUND_FINAL = 7'd80;

  // Digest word positions.
  localparam logic [2:0] WORD_FIRST = 3'd0;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_WAIT,
    ST_OUT
  } ctrl_state_t;

  // Source of the byte pushed into the block buffer.
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } push_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      push;
    push_sel_t push_sel;
    logic      init;
    logic [2:0] word_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_ready;
    logic fill_at_len;
    logic fill_at_last;
    logic busy;
  } dp_sts_t;

endpackage

[src/sha1_message_digest_unit.sv]
`timescale 1ns / 1ps

// SHA-1 hasher that takes one message word (a byte with present and end flags) per
// handshake and returns the 160-bit digest as five 32-bit words, most significant
// first, word_index 0..4, last_word on the fifth. While the block buffer has room a
// word is taken every cycle. Each 64-byte block keeps the single round unit busy for
// its 80 rounds and the chaining update, overlapped with filling of the next block.
// The last byte of the next block can enter only in the cycle after that. After the
// end flag, the marker, the zero bytes and the length bytes go in one after another,
// held while the round unit is busy, with one or two block compressions. The digest
// is offered once the round unit has finished the last block, and its words leave
// one per cycle while out_stall is low; no input word is taken until the fifth word
// is delivered.
module sha1_message_digest_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1md_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of bytes, padding and digest words.
  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_index     (word_index),
    .last_word      (last_word),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Block buffer, round unit and chaining words.
  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .sts         (sts),
    .digest_word (digest_word)
  );

endmodule

[src/sha1md_dp.sv]
`timescale 1ns / 1ps

module sha1md_dp (
  input  logic               clk,
  input  logic               rst,
  input  sha1md_pkg::dp_cmd_t cmd,
  input  logic [7:0]         data_byte,
  output sha1md_pkg::dp_sts_t sts,
  output logic [31:0]        digest_word
);
  import sha1md_pkg::*;

  // Block buffer as a byte shift line; the oldest byte ends up at the top.
  logic [511:0] fill_buf;
  logic [5:0]   fill_cnt;
  logic [60:0]  byte_total;

  // Round unit state.
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [6:0]  round;
  logic        busy;

  logic [7:0]   push_byte;
  logic [511:0] block;
  logic         start;
  logic [63:0]  bit_len;
  logic [5:0]   len_shift;
  logic [63:0]  len_word;
  logic [31:0]  f;
  logic [31:0] k;
  logic [31:0]  t;
  logic [31:0]  w_new;

  // Select the byte to push: message, marker, zero or a length byte.
  always_comb begin
    bit_len   = {byte_total, 3'b000};
    len_shift = {~fill_cnt[2:0], 3'b000};
    len_word  = bit_len >> len_shift;
    case (cmd.push_sel)
      SEL_MSG:  push_byte = data_byte;
      SEL_MARK: push_byte = PAD_MARK;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_word[7:0];
      default:  push_byte = 8'h00;
    endcase
  end

  assign block = {fill_buf[503:0], push_byte};
  assign start = cmd.push && (fill_cnt == FILL_LAST);

  // Round function, constant and new schedule word.
  always_comb begin
    if (round inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
      k = K_GROUP0;
    end else if (round inside {[7'd20:7'd39]}) begin
      f = b ^ c ^ d;
      k = K_GROUP1;
    end else if (round inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_GROUP2;
    end else begin
      f = b ^ c ^ d;
      k = K_GROUP3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
  end

  // Control state: fill count, length, chaining words and round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt   <= '0;
      byte_total <= '0;
      busy       <= 1'b0;
      round      <= '0;
      for (int i = 0; i < 5; i++) h[i] <= H_INIT[i];
    end else begin
      if (cmd.init) begin
        fill_cnt   <= '0;
        byte_total <= '0;
        for (int i = 0; i < 5; i++) h[i] <= H_INIT[i];
      end
      if (cmd.push) begin
        fill_cnt <= fill_cnt + 6'd1;
        if (cmd.push_sel == SEL_MSG) byte_total <= byte_total + 61'd1;
      end
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        if (round == ROUND_FINAL) begin
          busy <= 1'b0;
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
        end else begin
          round <= round + 7'd1;
        end
      end
    end
  end

  // Payload: byte shift line, schedule window and working words.
  always_ff @(posedge clk) begin
    if (cmd.push) fill_buf <= block;
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32 * i -: 32];
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (busy && (round != ROUND_FINAL)) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= {w_new[30:0], w_new[31]};
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  // A block may complete only once the round unit is free.
  assign sts.push_ready   = !((fill_cnt == FILL_LAST) && busy);
  assign sts.fill_at_len  = (fill_cnt == FILL_LEN_START);
  assign sts.fill_at_last = (fill_cnt == FILL_LAST);
  assign sts.busy         = busy;

  // Digest word selected by the controller.
  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      3'd4:    digest_word = h[4];
      default: digest_word = h[0];
    endcase
  end

  // A new block never starts while the round unit is at work.
  a_start_free: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("block started while round unit busy");

  // The round counter never runs past the chaining update.
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (round <= ROUND_FINAL))
    else $error("round counter out of range");

  // A started block is at work in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("round unit did not start");

endmodule

[src/sha1md_ctrl.sv]
`timescale 1ns / 1ps

module sha1md_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                byte_present,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          word_index,
  output logic                last_word,
  input  sha1md_pkg::dp_sts_t sts,
  output sha1md_pkg::dp_cmd_t cmd
);
  import sha1md_pkg::*;

  ctrl_state_t state, state_next;
  logic [2:0]  word_cnt, word_cnt_next;

  // State register and digest word counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      word_cnt <= WORD_FIRST;
    end else begin
      state    <= state_next;
      word_cnt <= word_cnt_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    word_cnt_next = word_cnt;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.push      = 1'b0;
    cmd.push_sel  = SEL_MSG;
    cmd.init      = 1'b0;
    cmd.word_sel  = word_cnt;
    case (state)
      ST_IDLE: begin
        in_stall = !sts.push_ready;
        if (in_valid && sts.push_ready) begin
          cmd.push = byte_present;
          if (end_of_message) state_next = ST_PAD_MARK;
        end
      end
      ST_PAD_MARK: begin
        cmd.push_sel = SEL_MARK;
        if (sts.push_ready) begin
          cmd.push   = 1'b1;
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        cmd.push_sel = SEL_ZERO;
        if (sts.fill_at_len) begin
          state_next = ST_PAD_LEN;
        end else if (sts.push_ready) begin
          cmd.push = 1'b1;
        end
      end
      ST_PAD_LEN: begin
        cmd.push_sel = SEL_LEN;
        if (sts.push_ready) begin
          cmd.push = 1'b1;
          if (sts.fill_at_last) state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!sts.busy) state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (word_cnt == WORD_LAST) begin
            word_cnt_next = WORD_FIRST;
            cmd.init      = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            word_cnt_next = word_cnt + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign word_index = word_cnt;
  assign last_word  = (word_cnt == WORD_LAST);

  // A byte is pushed only when the buffer can take it.
  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.push_ready)
    else $error("byte pushed into a full buffer");

  // The digest is offered only after the last block is finished.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !sts.busy)
    else $error("digest offered while round unit busy");

  // Taking the last word returns the block to the input state.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the digest");

endmodule
